// ===== rtl/core/fufla_pkg.sv =====
`timescale 1ns / 1ps

package fufla_pkg;

	localparam int MAX_UNITS = 1024;
	localparam int IDX_W = $clog2(MAX_UNITS);
	localparam int CNT_W = IDX_W + 1;
	localparam int LINK_W = IDX_W + 1;
	localparam int SIZE_W = 21;
	localparam int CHUNK_W = 11;
	localparam int ADDR_W = 32;
	localparam int GADDR_W = 33;
	localparam int PROD_W = IDX_W + SIZE_W;
	localparam int MIN_UNIT_SIZE = 8;
	localparam int RESET_UNIT_SIZE = 8;
	localparam int RESET_UNITS_PER_CHUNK = 20;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_OOM = 2'd1,
		STAT_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		CFG_UNIT_SIZE = 2'd0,
		CFG_UNITS_PER_CHUNK = 2'd1,
		CFG_BASE_ADDRESS = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_FILL,
		S_WAIT
	} state_t;

endpackage

// ===== rtl/core/fixed_unit_free_list_allocator.sv =====
`timescale 1ns / 1ps

// Fixed-size unit pool allocator with a LIFO free list held in a link memory.
// A request on the input channel (in_valid/in_stall) either allocates a unit
// (req_type 0) or frees unit_index (req_type 1). Each request yields exactly
// one result on the output channel (out_valid/out_stall): a status, and for a
// successful allocation the unit index and its byte address.
// A free finishes in the cycle of its request. An allocation from a nonempty
// list passes through S_POP, bounded by the registered read of the link memory
// at the head entry. An allocation on an empty list first links a fresh chunk,
// if one fits, one link memory write per cycle in S_FILL, and else reports OOM.
// The result is registered; S_WAIT holds it while the output register is full.
// The result register lets the block take the next request while a result is
// still held by a stalling receiver; if a second result is finished before the
// first is taken, the block holds it and stalls its input until the output
// register frees up.
// Reset empties the free list and clears the linked-unit count; the link
// memory needs no clearing pass. Configuration must be written only while no
// request is in flight; the user must keep to this, the block does not enforce it.
module fixed_unit_free_list_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               req_type,
	input  logic [fufla_pkg::IDX_W-1:0]        unit_index,
	output logic                               out_valid,
	input  logic                               out_stall,
	output fufla_pkg::status_t                 status,
	output logic [fufla_pkg::IDX_W-1:0]        granted_index,
	output logic [fufla_pkg::GADDR_W-1:0]      granted_address,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [fufla_pkg::ADDR_W-1:0]       cfg_data
);
	import fufla_pkg::*;

	state_t state_q, state_d;

	logic [SIZE_W-1:0] unit_size_q;
	logic [CHUNK_W-1:0] units_per_chunk_q;
	logic [ADDR_W-1:0] base_address_q;

	logic [IDX_W-1:0] head_q, head_d;
	logic head_valid_q, head_valid_d;
	logic [CNT_W-1:0] units_linked_q, units_linked_d;

	logic [LINK_W-1:0] link_mem [MAX_UNITS];
	logic [LINK_W-1:0] link_rd_s1;
	logic mem_we;
	logic [IDX_W-1:0] mem_wa, mem_ra;
	logic [LINK_W-1:0] mem_wd;

	logic [IDX_W-1:0] u_q, pop_idx;
	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0] fill_q, end_q, fill_nx, linked_nx;
	status_t st_q, fin_st, res_st;
	logic ok_q, fin_ok, res_ok, fin;

	logic [SIZE_W-1:0] eff_size;
	logic [CNT_W:0] chunk_end;
	logic chunk_fits, out_free, out_load;
	logic [GADDR_W-1:0] res_addr;

	logic out_valid_q;
	status_t status_q;
	logic [IDX_W-1:0] granted_index_q;
	logic [GADDR_W-1:0] granted_address_q;

	assign eff_size = (unit_size_q < SIZE_W'(MIN_UNIT_SIZE)) ? SIZE_W'(MIN_UNIT_SIZE) : unit_size_q;
	assign chunk_end = {1'b0, units_linked_q} + (CNT_W + 1)'(units_per_chunk_q);
	assign chunk_fits = (units_per_chunk_q != '0) && (chunk_end <= (CNT_W + 1)'(MAX_UNITS));
	assign pop_idx = head_valid_q ? head_q : units_linked_q[IDX_W-1:0];
	assign fill_nx = fill_q + 1'b1;
	assign linked_nx = units_linked_q + 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_wa = unit_index;
		mem_wd = '0;
		mem_ra = head_q;
		fin = 1'b0;
		fin_st = STAT_OK;
		fin_ok = 1'b0;
		head_d = head_q;
		head_valid_d = head_valid_q;
		units_linked_d = units_linked_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_FREE) begin
						fin = 1'b1;
						if ({1'b0, unit_index} >= units_linked_q) begin
							fin_st = STAT_BAD_FREE;
						end else begin
							mem_we = 1'b1;
							mem_wa = unit_index;
							mem_wd = {head_valid_q, head_valid_q ? head_q : {IDX_W{1'b0}}};
							head_d = unit_index;
							head_valid_d = 1'b1;
						end
					end else if (head_valid_q) begin
						state_d = S_POP;
					end else if (chunk_fits) begin
						state_d = S_FILL;
					end else begin
						fin = 1'b1;
						fin_st = STAT_OOM;
					end
				end
			end
			S_POP: begin
				fin = 1'b1;
				fin_ok = 1'b1;
				head_valid_d = link_rd_s1[IDX_W];
				head_d = link_rd_s1[IDX_W] ? link_rd_s1[IDX_W-1:0] : '0;
			end
			S_FILL: begin
				mem_we = 1'b1;
				mem_wa = fill_q[IDX_W-1:0];
				if (fill_nx < end_q) begin
					mem_wd = {1'b1, fill_nx[IDX_W-1:0]};
				end else begin
					mem_wd = '0;
					fin = 1'b1;
					fin_ok = 1'b1;
					units_linked_d = end_q;
					head_valid_d = (end_q > linked_nx);
					head_d = (end_q > linked_nx) ? linked_nx[IDX_W-1:0] : '0;
				end
			end
			S_WAIT: begin
			end
			default: begin
			end
		endcase

		res_st = (state_q == S_WAIT) ? st_q : fin_st;
		res_ok = (state_q == S_WAIT) ? ok_q : fin_ok;
		out_load = (fin || (state_q == S_WAIT)) && out_free;
		if (fin) begin
			state_d = out_free ? S_IDLE : S_WAIT;
		end else if ((state_q == S_WAIT) && out_free) begin
			state_d = S_IDLE;
		end
	end

	assign res_addr = res_ok ? ({1'b0, base_address_q} + GADDR_W'(prod_q)) : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		link_rd_s1 <= link_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			head_valid_q <= 1'b0;
			units_linked_q <= '0;
			out_valid_q <= 1'b0;
			unit_size_q <= SIZE_W'(RESET_UNIT_SIZE);
			units_per_chunk_q <= CHUNK_W'(RESET_UNITS_PER_CHUNK);
			base_address_q <= '0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			head_valid_q <= head_valid_d;
			units_linked_q <= units_linked_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_UNIT_SIZE: unit_size_q <= cfg_data[SIZE_W-1:0];
					CFG_UNITS_PER_CHUNK: units_per_chunk_q <= cfg_data[CHUNK_W-1:0];
					CFG_BASE_ADDRESS: base_address_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			u_q <= pop_idx;
			prod_q <= PROD_W'(pop_idx) * PROD_W'(eff_size);
			fill_q <= units_linked_q;
			end_q <= chunk_end[CNT_W-1:0];
		end else if (state_q == S_FILL) begin
			fill_q <= fill_nx;
		end
		if (fin) begin
			st_q <= fin_st;
			ok_q <= fin_ok;
		end
		if (out_load) begin
			status_q <= res_st;
			granted_index_q <= res_ok ? u_q : '0;
			granted_address_q <= res_addr;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign granted_index = granted_index_q;
	assign granted_address = granted_address_q;

	a_linked_bound: assert property (@(posedge clk) disable iff (!arst_n)
		units_linked_q <= CNT_W'(MAX_UNITS))
		else $error("Linked unit count exceeds the pool size.");

	a_head_linked: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid_q |-> ({1'b0, head_q} < units_linked_q))
		else $error("Free list head names a unit that was never linked.");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (fill_q < end_q))
		else $error("Chunk fill ran past the end of its chunk.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STAT_OK)) |-> (granted_index == '0 && granted_address == '0))
		else $error("Failed request carries a nonzero grant.");

endmodule

// ===== verif/fixed_unit_free_list_allocator_tb.sv =====
`timescale 1ns / 1ps

module fixed_unit_free_list_allocator_tb;
	import fufla_pkg::*;

	typedef struct {
		status_t              status;
		logic [IDX_W-1:0]     index;
		logic [GADDR_W-1:0]   address;
	} alloc_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 req_type = 1'b0;
	logic [IDX_W-1:0]     unit_index = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	status_t              status;
	logic [IDX_W-1:0]     granted_index;
	logic [GADDR_W-1:0]   granted_address;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;

	// Expected behavior of the pool, updated as each request is accepted.
	logic [SIZE_W-1:0]    pool_unit_size = SIZE_W'(RESET_UNIT_SIZE);
	logic [CHUNK_W-1:0]   pool_chunk = CHUNK_W'(RESET_UNITS_PER_CHUNK);
	logic [ADDR_W-1:0]    pool_base = '0;
	logic [IDX_W-1:0]     pool_head = '0;
	bit                   pool_head_valid = 1'b0;
	logic [IDX_W-1:0]     link_next [MAX_UNITS];
	bit                   link_ok [MAX_UNITS];
	int unsigned          linked_count = 0;

	alloc_result_t        expected_grants [$];
	alloc_result_t        want;
	logic [IDX_W-1:0]     held_units [$];
	int                   fault_count = 0;
	int unsigned          stall_left = 0;
	bit                   no_idle = 1'b0;

	fixed_unit_free_list_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.unit_index(unit_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.granted_index(granted_index),
		.granted_address(granted_address),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bit link_fresh_chunk();
		int unsigned n;
		int unsigned first;
		n = pool_chunk;
		first = linked_count;
		if (n == 0 || first + n > MAX_UNITS)
			return 1'b0;
		for (int unsigned i = 0; i < n; i++) begin
			if (i + 1 < n) begin
				link_next[first + i] = IDX_W'(first + i + 1);
				link_ok[first + i] = 1'b1;
			end else begin
				link_next[first + i] = '0;
				link_ok[first + i] = 1'b0;
			end
		end
		pool_head = IDX_W'(first);
		pool_head_valid = 1'b1;
		linked_count = first + n;
		return 1'b1;
	endfunction

	function automatic alloc_result_t pool_predict(req_t kind, logic [IDX_W-1:0] idx);
		alloc_result_t res;
		logic [IDX_W-1:0] u;
		logic [63:0] size;
		logic [63:0] addr;
		res.status = STAT_OK;
		res.index = '0;
		res.address = '0;
		if (kind == REQ_ALLOC) begin
			if (!pool_head_valid && !link_fresh_chunk()) begin
				res.status = STAT_OOM;
				return res;
			end
			u = pool_head;
			pool_head_valid = link_ok[u];
			pool_head = link_ok[u] ? link_next[u] : '0;
			size = (pool_unit_size < MIN_UNIT_SIZE) ? 64'(MIN_UNIT_SIZE) : 64'(pool_unit_size);
			addr = 64'(pool_base) + 64'(u) * size;
			res.index = u;
			res.address = addr[GADDR_W-1:0];
			held_units.push_back(u);
		end else if (idx >= linked_count) begin
			res.status = STAT_BAD_FREE;
		end else begin
			link_next[idx] = pool_head_valid ? pool_head : '0;
			link_ok[idx] = pool_head_valid;
			pool_head = idx;
			pool_head_valid = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_grants.size() == 0) begin
				$error("unexpected result: status %0d index %0d address %0h",
					status, granted_index, granted_address);
				fault_count++;
			end else begin
				want = expected_grants.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fault_count++;
				end
				if (granted_index !== want.index) begin
					$error("granted_index: expected %0d, actual %0d",
						want.index, granted_index);
					fault_count++;
				end
				if (granted_address !== want.address) begin
					$error("granted_address: expected %0h, actual %0h",
						want.address, granted_address);
					fault_count++;
				end
			end
		end
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall)
				stall_left = no_idle ? 0 : $urandom_range(0, 9);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	task automatic send_request(req_t kind, logic [IDX_W-1:0] idx);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		unit_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_grants.push_back(pool_predict(kind, idx));
	endtask

	task automatic release_held(int pick);
		logic [IDX_W-1:0] idx;
		idx = held_units[pick];
		held_units.delete(pick);
		send_request(REQ_FREE, idx);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_grants.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_pool_config(logic [SIZE_W-1:0] size, logic [CHUNK_W-1:0] chunk,
			logic [ADDR_W-1:0] base);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_UNIT_SIZE;
		cfg_data <= ADDR_W'(size);
		@(posedge clk);
		cfg_index <= CFG_UNITS_PER_CHUNK;
		cfg_data <= ADDR_W'(chunk);
		@(posedge clk);
		cfg_index <= CFG_BASE_ADDRESS;
		cfg_data <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_unit_size = size;
		pool_chunk = chunk;
		pool_base = base;
		@(posedge clk);
	endtask

	task automatic drain_free_list();
		int guard;
		guard = 0;
		while (pool_head_valid && guard < MAX_UNITS) begin
			send_request(REQ_ALLOC, IDX_W'($urandom));
			guard++;
		end
	endtask

	// Mostly balanced allocate and free traffic; the remainder frees units
	// that were never linked, or allocates once the whole pool is linked.
	task automatic run_mix(int count, bit quiet);
		int r;
		int n;
		int alloc_weight;
		no_idle = quiet;
		for (n = 0; n < count; n++) begin
			if (n % 97 == 96)
				wait_idle();
			r = $urandom_range(0, 99);
			alloc_weight = (held_units.size() < 40) ? 55 : 30;
			if (r < alloc_weight)
				send_request(REQ_ALLOC, IDX_W'($urandom));
			else if (r < 90 && held_units.size() != 0)
				release_held($urandom_range(0, held_units.size() - 1));
			else if (linked_count < MAX_UNITS)
				send_request(REQ_FREE,
					IDX_W'($urandom_range(linked_count, MAX_UNITS - 1)));
			else
				send_request(REQ_ALLOC, IDX_W'($urandom));
		end
		no_idle = 1'b0;
	endtask

	task automatic test_reset_values();
		send_request(REQ_FREE, '0);
		send_request(REQ_FREE, '1);
		send_request(REQ_ALLOC, '1);
		send_request(REQ_ALLOC, '0);
		release_held(0);
		send_request(REQ_ALLOC, IDX_W'($urandom));
		send_request(REQ_FREE, IDX_W'(RESET_UNITS_PER_CHUNK));
	endtask

	task automatic test_unit_size_extremes();
		set_pool_config(SIZE_W'(1), CHUNK_W'(20), 32'hFFFF_FFFF);
		send_request(REQ_ALLOC, '0);
		set_pool_config(SIZE_W'(1048576), CHUNK_W'(20), 32'hFFFF_FFFF);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '0);
		set_pool_config(SIZE_W'(MIN_UNIT_SIZE), CHUNK_W'(20), '0);
		send_request(REQ_ALLOC, '0);
	endtask

	task automatic test_small_chunks();
		set_pool_config(SIZE_W'(16), CHUNK_W'(1), 32'h0000_0100);
		drain_free_list();
		send_request(REQ_ALLOC, '0);
		release_held(held_units.size() - 1);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '0);
		set_pool_config(SIZE_W'(16), CHUNK_W'(0), 32'h0000_0100);
		drain_free_list();
		send_request(REQ_ALLOC, '0);
	endtask

	task automatic test_random_growth();
		set_pool_config(SIZE_W'(8), CHUNK_W'(5), 32'h0000_1000);
		run_mix(180, 1'b0);
		set_pool_config(SIZE_W'(4096), CHUNK_W'(13), $urandom);
		run_mix(180, 1'b1);
		set_pool_config(SIZE_W'(1048576), CHUNK_W'(1), 32'hFFFF_FFFF);
		run_mix(180, 1'b0);
		set_pool_config(SIZE_W'($urandom_range(8, 1048576)), CHUNK_W'($urandom_range(2, 40)),
			$urandom);
		run_mix(180, 1'b0);
	endtask

	task automatic test_chunk_limits();
		set_pool_config(SIZE_W'(64), CHUNK_W'(1024), '0);
		drain_free_list();
		send_request(REQ_ALLOC, '0);
		set_pool_config(SIZE_W'(64), CHUNK_W'(2047), '0);
		send_request(REQ_ALLOC, '0);
		set_pool_config(SIZE_W'(64), CHUNK_W'(MAX_UNITS - linked_count), 32'h8000_0000);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '0);
	endtask

	task automatic test_full_pool();
		set_pool_config(SIZE_W'($urandom_range(1, 1048576)), CHUNK_W'($urandom), $urandom);
		run_mix(250, 1'b0);
		set_pool_config(SIZE_W'(MIN_UNIT_SIZE), CHUNK_W'(1), 32'hFFFF_FFFF);
		run_mix(200, 1'b0);
	endtask

	task automatic test_double_free();
		logic [IDX_W-1:0] idx;
		if (held_units.size() == 0)
			send_request(REQ_ALLOC, '0);
		wait_idle();
		idx = held_units.pop_back();
		send_request(REQ_FREE, idx);
		send_request(REQ_FREE, idx);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_unit_size_extremes();
		test_small_chunks();
		test_random_growth();
		test_chunk_limits();
		test_full_pool();
		test_double_free();
		wait_idle();
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/fufla_pkg.sv
rtl/core/fixed_unit_free_list_allocator.sv
verif/fixed_unit_free_list_allocator_tb.sv
